>>> rtl/core/agsg_pkg.sv
// shared constants and types for the anagram signature grouper
`default_nettype none

package agsg_pkg;

  localparam int ALPHABET      = 26;
  localparam int LETTER_W      = 7;
  localparam int LETTER_BASE   = 97;
  localparam int MAX_WORD_LEN  = 24;
  localparam int LEN_W         = $clog2(MAX_WORD_LEN + 2);
  localparam int BIN_W         = $clog2(ALPHABET);
  localparam int COUNT_W       = 16;
  localparam int INDEX_OUT_W   = 6;
  localparam int GROUPS_OUT_W  = 7;
  localparam int MAX_GROUPS_DEF = 64;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [ALPHABET-1:0][LEN_W-1:0] hist;
    logic [LEN_W-1:0]               len;
  } sig_t;

  typedef struct packed {
    logic               valid;
    logic               matched;
    logic               new_grp;
    logic [COUNT_W-1:0] count;
    sig_t               sig;
  } token_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] val);
    sat_inc = (val == COUNT_MAX) ? val : val + 1'b1;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/agsg_word.sv
// letter histogram and length of the word being collected
`default_nettype none

module agsg_word
  import agsg_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                add,
  input  wire logic                clear,
  input  wire logic [LETTER_W-1:0] code,
  output sig_t                     sig_next
);

  sig_t sig;
  logic letter_ok;
  logic [LETTER_W-1:0] offset;
  logic [BIN_W-1:0] bin;

  assign letter_ok = (code >= LETTER_W'(LETTER_BASE)) &&
                     (code < LETTER_W'(LETTER_BASE + ALPHABET));
  assign offset = code - LETTER_W'(LETTER_BASE);
  assign bin = offset[BIN_W-1:0];

  always_comb begin
    sig_next = sig;
    if (add && letter_ok && (sig.len <= LEN_W'(MAX_WORD_LEN))) begin
      sig_next.len = sig.len + 1'b1;
      if (sig.len < LEN_W'(MAX_WORD_LEN)) begin
        sig_next.hist[bin] = sig.hist[bin] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      sig <= '0;
    end else begin
      sig <= sig_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/agsg_cell.sv
// one group slot of the search chain: stored signature and member count
`default_nettype none

module agsg_cell
  import agsg_pkg::*;
#(
  parameter int IDX_W = INDEX_OUT_W
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             occupied,
  input  wire logic [IDX_W-1:0] cell_index,
  input  wire token_t           tin,
  input  wire logic [IDX_W-1:0] idx_in,
  output token_t                tout,
  output logic      [IDX_W-1:0] idx_out
);

  sig_t               sig;
  logic [COUNT_W-1:0] members;
  logic               hit;
  logic               alloc;
  logic [COUNT_W-1:0] members_inc;

  assign hit   = tin.valid && !tin.matched && occupied && (sig == tin.sig);
  assign alloc = tin.valid && !tin.matched && !occupied;
  assign members_inc = sat_inc(members);

  always_ff @(posedge clk) begin
    if (alloc) begin
      sig     <= tin.sig;
      members <= COUNT_W'(1);
    end else if (hit) begin
      members <= members_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tout.valid <= 1'b0;
    end else begin
      tout.valid <= tin.valid;
    end
    tout.matched <= tin.matched || hit || alloc;
    tout.new_grp <= tin.new_grp || alloc;
    tout.sig     <= tin.sig;
    if (alloc) begin
      tout.count <= COUNT_W'(1);
      idx_out    <= cell_index;
    end else if (hit) begin
      tout.count <= members_inc;
      idx_out    <= cell_index;
    end else begin
      tout.count <= tin.count;
      idx_out    <= idx_in;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/anagram_signature_grouper.sv
// top level: word collection, signature search chain and result register
//
//  channel   dir  width   contents
//  s_*       in   8+1+1   tdata letter_code, tlast last_letter, tuser empty_word
//  m_*       out  32+3    tdata index/count/groups, tuser new/empty/overflow
//
//  letters are taken one per cycle; a word end that needs a table search
//  walks the chain of MAX_GROUPS cells one cell per cycle, so a finished
//  non-empty word passes the chain entry register, every cell, then the result register.
//  empty and over-long words give their result in the next cycle.
//  a word end is held off while a search runs or the result register is full.
//  rst clears word state, group count and empty count; table contents need none.
`default_nettype none

module anagram_signature_grouper
  import agsg_pkg::*;
#(
  parameter int MAX_GROUPS = MAX_GROUPS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [6:0] letter_code, [7] zero
  input  wire logic        s_tlast,
  input  wire logic [0:0]  s_tuser,   // [0] empty_word
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [5:0] group_index, [21:6] member_count,
                                      // [28:22] groups_in_use, [31:29] zero
  output logic [2:0]       m_tuser    // [0] new_group, [1] is_empty_member, [2] overflow
);

  localparam int IDX_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int GT_W  = $clog2(MAX_GROUPS + 1);

  logic                   ends_word;
  logic                   can_finish;
  logic                   accept;
  logic                   empty_item;
  sig_t                   sig_next;
  logic                   launch;
  logic                   finish_empty;
  logic                   finish_long;
  logic                   busy;
  logic [GT_W-1:0]        group_total;
  logic [COUNT_W-1:0]     empty_total;
  logic [COUNT_W-1:0]     empty_total_next;

  token_t                 chain_tok [MAX_GROUPS+1];
  logic [IDX_W-1:0]       chain_idx [MAX_GROUPS+1];
  token_t                 exit_tok;
  logic [IDX_W-1:0]       exit_idx;
  logic [GT_W-1:0]        group_total_next;

  logic                   out_valid;
  logic [INDEX_OUT_W-1:0] out_index;
  logic                   out_new;
  logic                   out_empty;
  logic [COUNT_W-1:0]     out_count;
  logic [GROUPS_OUT_W-1:0] out_groups;
  logic                   out_ovf;

  logic [IDX_W+INDEX_OUT_W-1:0]   idx_ext;
  logic [GT_W+GROUPS_OUT_W-1:0]   gt_ext;
  logic [GT_W+GROUPS_OUT_W-1:0]   gt_next_ext;

  assign empty_item = s_tuser[0];
  assign ends_word  = s_tlast || empty_item;
  assign can_finish = !busy && (!out_valid || m_tready);
  assign s_tready   = !ends_word || can_finish;
  assign accept     = s_tvalid && s_tready;

  agsg_word u_word (
    .clk      (clk),
    .rst      (rst),
    .add      (accept && !empty_item),
    .clear    (accept && ends_word),
    .code     (s_tdata[LETTER_W-1:0]),
    .sig_next (sig_next)
  );

  always_comb begin
    finish_empty = 1'b0;
    finish_long  = 1'b0;
    launch       = 1'b0;
    if (accept && ends_word) begin
      priority if (empty_item || (sig_next.len == '0)) begin
        finish_empty = 1'b1;
      end else if (sig_next.len > LEN_W'(MAX_WORD_LEN)) begin
        finish_long = 1'b1;
      end else begin
        launch = 1'b1;
      end
    end
  end

  assign empty_total_next = sat_inc(empty_total);

  // search chain entry
  always_ff @(posedge clk) begin
    if (rst) begin
      chain_tok[0].valid <= 1'b0;
    end else begin
      chain_tok[0].valid <= launch;
    end
    chain_tok[0].matched <= 1'b0;
    chain_tok[0].new_grp <= 1'b0;
    chain_tok[0].count   <= '0;
    chain_tok[0].sig     <= sig_next;
    chain_idx[0]         <= '0;
  end

  for (genvar i = 0; i < MAX_GROUPS; i++) begin : g_cell
    agsg_cell #(
      .IDX_W (IDX_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .occupied   (GT_W'(i) < group_total),
      .cell_index (IDX_W'(i)),
      .tin        (chain_tok[i]),
      .idx_in     (chain_idx[i]),
      .tout       (chain_tok[i+1]),
      .idx_out    (chain_idx[i+1])
    );
  end

  assign exit_tok = chain_tok[MAX_GROUPS];
  assign exit_idx = chain_idx[MAX_GROUPS];
  assign group_total_next = group_total + GT_W'(exit_tok.new_grp);

  assign idx_ext     = {{INDEX_OUT_W{1'b0}}, exit_idx};
  assign gt_ext      = {{GROUPS_OUT_W{1'b0}}, group_total};
  assign gt_next_ext = {{GROUPS_OUT_W{1'b0}}, group_total_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      group_total <= '0;
      empty_total <= '0;
    end else begin
      if (launch) begin
        busy <= 1'b1;
      end else if (exit_tok.valid) begin
        busy <= 1'b0;
      end
      if (exit_tok.valid) begin
        group_total <= group_total_next;
      end
      if (finish_empty) begin
        empty_total <= empty_total_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_empty || finish_long || exit_tok.valid) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_empty) begin
      out_index  <= '0;
      out_new    <= 1'b0;
      out_empty  <= 1'b1;
      out_count  <= empty_total_next;
      out_groups <= gt_ext[GROUPS_OUT_W-1:0];
      out_ovf    <= 1'b0;
    end else if (finish_long) begin
      out_index  <= '0;
      out_new    <= 1'b0;
      out_empty  <= 1'b0;
      out_count  <= '0;
      out_groups <= gt_ext[GROUPS_OUT_W-1:0];
      out_ovf    <= 1'b1;
    end else if (exit_tok.valid) begin
      out_empty  <= 1'b0;
      out_groups <= gt_next_ext[GROUPS_OUT_W-1:0];
      if (exit_tok.matched) begin
        out_index <= idx_ext[INDEX_OUT_W-1:0];
        out_new   <= exit_tok.new_grp;
        out_count <= exit_tok.count;
        out_ovf   <= 1'b0;
      end else begin
        out_index <= '0;
        out_new   <= 1'b0;
        out_count <= '0;
        out_ovf   <= 1'b1;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_groups, out_count, out_index};
  assign m_tuser  = {out_ovf, out_empty, out_new};

endmodule

`default_nettype wire

>>> tb/anagram_signature_grouper_tb.sv
// testbench for the anagram signature grouper: directed and random words checked against a group model
module anagram_signature_grouper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import agsg_pkg::*;

  localparam int NGROUPS      = MAX_GROUPS_DEF;
  localparam int RANDOM_ITEMS = 2000;
  localparam int STALL_LIMIT  = 4000;
  localparam int POOL_SIZE    = 40;

  typedef struct packed {
    logic [LETTER_W-1:0] code;
    logic                last;
    logic                empty;
  } letter_t;

  typedef struct packed {
    logic [INDEX_OUT_W-1:0]  group_index;
    logic                    new_group;
    logic                    is_empty;
    logic [COUNT_W-1:0]      count;
    logic [GROUPS_OUT_W-1:0] groups;
    logic                    overflow;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [6:0] letter_code, [7] zero
  logic        s_tlast = 1'b0;
  logic [0:0]  s_tuser = '0;   // [0] empty_word
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [5:0] group_index, [21:6] member_count, [28:22] groups_in_use
  logic [2:0]  m_tuser;        // [0] new_group, [1] is_empty_member, [2] overflow

  anagram_signature_grouper #(.MAX_GROUPS(NGROUPS)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tlast(s_tlast), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  letter_t pending_letters[$];
  result_t expected_groups[$];
  int      errors = 0;
  int      total_items = 0;
  int      sent_cnt = 0;
  int      stall_cycles = 0;

  logic [LETTER_W-1:0] word_buf[$];
  logic [LETTER_W-1:0] pool_letters[POOL_SIZE][MAX_WORD_LEN];
  int                  pool_len[POOL_SIZE];

  // group model state
  logic [ALPHABET-1:0][LEN_W-1:0] letter_hist = '0;
  logic [LEN_W:0]                 word_len = '0;
  logic [ALPHABET-1:0][LEN_W-1:0] sig_letters[NGROUPS];
  logic [LEN_W-1:0]               sig_len[NGROUPS];
  logic [COUNT_W-1:0]             group_members[NGROUPS];
  int                             groups_used = 0;
  logic [COUNT_W-1:0]             empty_members = '0;

  task automatic group_word(input letter_t it);
    result_t r;
    int      g;
    int      found;
    r = '0;
    found = -1;
    if (!it.empty && it.code >= LETTER_BASE && it.code < LETTER_BASE + ALPHABET &&
        word_len <= MAX_WORD_LEN) begin
      word_len = word_len + 1'b1;
      if (word_len <= MAX_WORD_LEN)
        letter_hist[it.code - LETTER_BASE] = letter_hist[it.code - LETTER_BASE] + 1'b1;
    end
    if (!it.empty && !it.last) return;
    if (it.empty || word_len == 0) begin
      if (empty_members != COUNT_MAX) empty_members = empty_members + 1'b1;
      r.is_empty = 1'b1;
      r.count = empty_members;
    end else if (word_len > MAX_WORD_LEN) begin
      r.overflow = 1'b1;
    end else begin
      for (g = 0; g < groups_used; g++)
        if (found < 0 && sig_len[g] == word_len && sig_letters[g] == letter_hist) found = g;
      if (found >= 0) begin
        if (group_members[found] != COUNT_MAX) group_members[found] = group_members[found] + 1'b1;
        r.group_index = INDEX_OUT_W'(found);
        r.count = group_members[found];
      end else if (groups_used >= NGROUPS) begin
        r.overflow = 1'b1;
      end else begin
        sig_letters[groups_used] = letter_hist;
        sig_len[groups_used] = LEN_W'(word_len);
        group_members[groups_used] = 1;
        r.group_index = INDEX_OUT_W'(groups_used);
        r.new_group = 1'b1;
        r.count = 1;
        groups_used++;
      end
    end
    r.groups = GROUPS_OUT_W'(groups_used);
    letter_hist = '0;
    word_len = '0;
    expected_groups.push_back(r);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic push_letter(input logic [LETTER_W-1:0] code, input logic last, input logic empty);
    letter_t it;
    it.code = code;
    it.last = last;
    it.empty = empty;
    pending_letters.push_back(it);
  endtask

  task automatic flush_word();
    int i;
    for (i = 0; i < word_buf.size(); i++) push_letter(word_buf[i], i == word_buf.size() - 1, 1'b0);
    word_buf.delete();
  endtask

  function automatic logic [LETTER_W-1:0] any_letter();
    return LETTER_W'(LETTER_BASE + $urandom_range(ALPHABET - 1));
  endfunction

  function automatic logic [LETTER_W-1:0] non_letter();
    if ($urandom_range(1)) return LETTER_W'($urandom_range(LETTER_BASE - 1));
    return LETTER_W'($urandom_range(127, LETTER_BASE + ALPHABET));
  endfunction

  // shuffled copy of a pool word, so it lands in the same group
  task automatic load_anagram(input int p);
    int                  j;
    int                  k;
    logic [LETTER_W-1:0] t;
    word_buf.delete();
    for (j = 0; j < pool_len[p]; j++) word_buf.push_back(pool_letters[p][j]);
    for (j = word_buf.size() - 1; j > 0; j--) begin
      k = $urandom_range(j);
      t = word_buf[j];
      word_buf[j] = word_buf[k];
      word_buf[k] = t;
    end
  endtask

  always @(posedge clk) begin : drive
    letter_t it;
    int      tx_idle;
    int      rx_idle;
    tx_idle = 0;
    rx_idle = 0;
    if (sent_cnt < total_items / 3) begin
      tx_idle = 33;
      rx_idle = 58;
    end else if (sent_cnt < 2 * total_items / 3) begin
      tx_idle = 58;
      rx_idle = 33;
    end
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= $urandom_range(99) >= rx_idle;
      if (!s_tvalid || s_tready) begin
        if (pending_letters.size() != 0 && $urandom_range(99) >= tx_idle) begin
          it = pending_letters.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {1'b0, it.code};
          s_tlast <= it.last;
          s_tuser <= it.empty;
          sent_cnt <= sent_cnt + 1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    result_t want;
    letter_t seen;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_groups.size() == 0) begin
          $display("%0t: unexpected word result, expected none, actual tdata=%h tuser=%b",
                   $time, m_tdata, m_tuser);
          errors++;
        end else begin
          want = expected_groups.pop_front();
          check_field("group_index", want.group_index, m_tdata[5:0]);
          check_field("member_count", want.count, m_tdata[21:6]);
          check_field("groups_in_use", want.groups, m_tdata[28:22]);
          check_field("new_group", want.new_group, m_tuser[0]);
          check_field("is_empty_member", want.is_empty, m_tuser[1]);
          check_field("overflow", want.overflow, m_tuser[2]);
        end
      end
      if (s_tvalid && s_tready) begin
        seen.code = s_tdata[LETTER_W-1:0];
        seen.last = s_tlast;
        seen.empty = s_tuser[0];
        group_word(seen);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int i;
    int j;
    int n;
    int r;
    int target;
    push_letter(LETTER_W'(LETTER_BASE), 1'b1, 1'b0);
    push_letter(LETTER_W'(LETTER_BASE + ALPHABET - 1), 1'b1, 1'b0);
    push_letter(LETTER_W'(LETTER_BASE + ALPHABET - 1), 1'b0, 1'b0);
    push_letter(LETTER_W'(LETTER_BASE), 1'b1, 1'b0);
    push_letter(LETTER_W'(LETTER_BASE), 1'b0, 1'b0);
    push_letter(LETTER_W'(LETTER_BASE + ALPHABET - 1), 1'b1, 1'b0);
    push_letter('1, 1'b1, 1'b1);
    // non-letter that ends a word with nothing in it
    push_letter('0, 1'b1, 1'b0);
    // empty word cutting a partial word
    push_letter(LETTER_W'(LETTER_BASE + 1), 1'b0, 1'b0);
    push_letter('0, 1'b0, 1'b1);
    push_letter(LETTER_W'(LETTER_BASE + 2), 1'b0, 1'b0);
    push_letter(LETTER_W'(LETTER_BASE - 1), 1'b1, 1'b0);
    push_letter(LETTER_W'(LETTER_BASE + ALPHABET), 1'b0, 1'b0);
    push_letter(LETTER_W'(LETTER_BASE + 2), 1'b1, 1'b0);
    push_letter(LETTER_W'(LETTER_BASE), 1'b1, 1'b0);

    for (i = 0; i < POOL_SIZE; i++) begin
      pool_len[i] = ($urandom_range(7) == 0) ? $urandom_range(MAX_WORD_LEN, 18)
                                              : $urandom_range(8, 1);
      for (j = 0; j < MAX_WORD_LEN; j++) pool_letters[i][j] = any_letter();
    end

    target = pending_letters.size() + RANDOM_ITEMS;
    while (pending_letters.size() < target) begin
      r = $urandom_range(99);
      if (r < 55) begin
        load_anagram($urandom_range(POOL_SIZE - 1));
        flush_word();
      end else if (r < 72) begin
        n = ($urandom_range(3) == 0) ? $urandom_range(MAX_WORD_LEN + 6, MAX_WORD_LEN + 1)
                                     : $urandom_range(MAX_WORD_LEN, 1);
        word_buf.delete();
        for (i = 0; i < n; i++) word_buf.push_back(any_letter());
        flush_word();
      end else if (r < 78) begin
        push_letter(LETTER_W'($urandom_range(127)), 1'($urandom_range(1)), 1'b1);
      end else if (r < 84) begin
        n = $urandom_range(5, 1);
        for (i = 0; i < n; i++) push_letter(any_letter(), 1'b0, 1'b0);
        push_letter(LETTER_W'($urandom_range(127)), 1'($urandom_range(1)), 1'b1);
      end else if (r < 94) begin
        // pool word with stray codes, sometimes ended by a stray code
        load_anagram($urandom_range(POOL_SIZE - 1));
        n = $urandom_range(1);
        for (i = 0; i < word_buf.size(); i++) begin
          if ($urandom_range(2) == 0) push_letter(non_letter(), 1'b0, 1'b0);
          push_letter(word_buf[i], (i == word_buf.size() - 1) && n == 1, 1'b0);
        end
        if (n == 0) push_letter(non_letter(), 1'b1, 1'b0);
        word_buf.delete();
      end else begin
        push_letter(non_letter(), 1'($urandom_range(1)), 1'b0);
      end
    end
    total_items = pending_letters.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    while (pending_letters.size() != 0 || s_tvalid || expected_groups.size() != 0)
      @(negedge clk);
    repeat (2 * NGROUPS + 20) @(negedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/agsg_pkg.sv
rtl/core/agsg_word.sv
rtl/core/agsg_cell.sv
rtl/core/anagram_signature_grouper.sv
tb/anagram_signature_grouper_tb.sv
